### rtl/ssir_pkg.sv
// ----------------------------------------------------------------------------
// ssir_pkg
// Types and constants shared by the serial shift-in reader modules.
// ----------------------------------------------------------------------------
package ssir_pkg;

  // Configuration port sizing
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIT_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXTRA_PULSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INIT_CLOCK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_READY_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAIT_LIMIT  = 3'd5;

  // Register reset values
  localparam logic [5:0]  RST_BIT_COUNT   = 6'd24;
  localparam logic [7:0]  RST_EXTRA_PULSE = 8'd1;
  localparam logic [15:0] RST_HALF_PERIOD = 16'd1;
  localparam logic        RST_INIT_CLOCK  = 1'b0;
  localparam logic        RST_READY_LEVEL = 1'b0;
  localparam logic [15:0] RST_WAIT_LIMIT  = 16'd1000;

  // Width of the reported value field
  localparam int OUT_VALUE_W = 32;

  typedef struct packed {
    logic [5:0]  bit_count;
    logic [7:0]  extra_pulses;
    logic [15:0] half_period_ticks;
    logic        initial_clock_level;
    logic        ready_level;
    logic [15:0] wait_limit;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic data_level;
  } in_t;

  typedef struct packed {
    logic                   clock_level;
    logic                   busy_res;
    logic                   done_res;
    logic                   timed_out;
    logic [OUT_VALUE_W-1:0] value;
  } out_t;

endpackage

### rtl/ssir_cfg.sv
// ----------------------------------------------------------------------------
// ssir_cfg
// Configuration register file of the serial shift-in reader.
// ----------------------------------------------------------------------------
module ssir_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ssir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssir_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ssir_pkg::cfg_t                    cfg
);

  ssir_pkg::cfg_t cfg_r;

  // Write one register per enabled cycle; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_count           <= ssir_pkg::RST_BIT_COUNT;
      cfg_r.extra_pulses        <= ssir_pkg::RST_EXTRA_PULSE;
      cfg_r.half_period_ticks   <= ssir_pkg::RST_HALF_PERIOD;
      cfg_r.initial_clock_level <= ssir_pkg::RST_INIT_CLOCK;
      cfg_r.ready_level         <= ssir_pkg::RST_READY_LEVEL;
      cfg_r.wait_limit          <= ssir_pkg::RST_WAIT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        ssir_pkg::CFG_IDX_BIT_COUNT:   cfg_r.bit_count           <= cfg_data[5:0];
        ssir_pkg::CFG_IDX_EXTRA_PULSE: cfg_r.extra_pulses        <= cfg_data[7:0];
        ssir_pkg::CFG_IDX_HALF_PERIOD: cfg_r.half_period_ticks   <= cfg_data;
        ssir_pkg::CFG_IDX_INIT_CLOCK:  cfg_r.initial_clock_level <= cfg_data[0];
        ssir_pkg::CFG_IDX_READY_LEVEL: cfg_r.ready_level         <= cfg_data[0];
        ssir_pkg::CFG_IDX_WAIT_LIMIT:  cfg_r.wait_limit          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/serial_shift_in_reader_core.sv
// ----------------------------------------------------------------------------
// serial_shift_in_reader_core
// Tick-driven sequencer that clocks serial data in from a load-cell converter.
// ----------------------------------------------------------------------------
// Usage:
//   Every input beat is one time tick carrying a start request and the sampled
//   data-pin level. Every accepted beat yields exactly one result beat with the
//   clock-pin level for that tick, busy/done/timeout flags and, on the done
//   tick, the shifted-in value (all ones on timeout, zero otherwise).
//   The configuration port writes one register per cycle; write it only while
//   no read is in progress and no result is pending.
// Timing and throughput:
//   A result appears in the cycle after its tick is accepted. One tick is
//   taken every cycle unless the receiver stalls; the sequencer step is a
//   single pass of logic between the state and result registers.
// Stall:
//   While the receiver stalls, the result register holds its beat and the
//   input side stalls too; a tick is still taken in the cycle the pending
//   result leaves.
// Reset:
//   Synchronous, active low. The sequencer goes idle with the clock level low,
//   counters and shift register cleared, and registers take their defaults.
// ----------------------------------------------------------------------------
module serial_shift_in_reader_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ssir_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ssir_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [ssir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssir_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW, PH_XHIGH, PH_XLOW
  } phase_t;

  localparam int OW = ssir_pkg::OUT_VALUE_W;

  ssir_pkg::cfg_t cfg;

  ssir_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  phase_t                 phase_r,  phase_nxt;
  logic                   clk_r,    clk_nxt;
  logic [5:0]             bits_r,   bits_nxt;
  logic [7:0]             pulses_r, pulses_nxt;
  logic [15:0]            tick_r,   tick_nxt;
  logic [15:0]            wait_r,   wait_nxt;
  logic [VALUE_WIDTH-1:0] shift_r,  shift_nxt;
  logic                   out_valid_r;
  ssir_pkg::out_t         out_data_r, res;

  logic                   accept;
  logic                   adv_go;
  logic                   res_done, res_tmo;
  logic [VALUE_WIDTH-1:0] res_val;
  logic [VALUE_WIDTH+OW-1:0] res_ext;
  logic [16:0]            tick_inc, wait_inc, half_eff, limit_eff;

  // Accept a tick unless a pending result is held by the receiver
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Zero period or zero limit behave as one
  assign half_eff  = (cfg.half_period_ticks == 16'd0) ? 17'd1 : {1'b0, cfg.half_period_ticks};
  assign limit_eff = (cfg.wait_limit == 16'd0) ? 17'd1 : {1'b0, cfg.wait_limit};
  assign tick_inc  = {1'b0, tick_r} + 17'd1;
  assign wait_inc  = {1'b0, wait_r} + 17'd1;

  // Advance the sequencer by one tick
  always_comb begin
    phase_nxt  = phase_r;
    clk_nxt    = clk_r;
    bits_nxt   = bits_r;
    pulses_nxt = pulses_r;
    tick_nxt   = tick_r;
    wait_nxt   = wait_r;
    shift_nxt  = shift_r;
    adv_go     = 1'b0;
    res_done   = 1'b0;
    res_tmo    = 1'b0;
    res_val    = '0;

    case (phase_r)
      PH_WAIT: begin
        if (in_data.data_level == cfg.ready_level) begin
          adv_go = 1'b1;
        end else if (wait_inc >= limit_eff) begin
          wait_nxt  = 16'd0;
          phase_nxt = PH_IDLE;
          res_done  = 1'b1;
          res_tmo   = 1'b1;
          res_val   = '1;
        end else begin
          wait_nxt = wait_inc[15:0];
        end
      end
      PH_HIGH, PH_XHIGH: begin
        clk_nxt = 1'b1;
        if (tick_inc >= half_eff) begin
          tick_nxt = 16'd0;
          if (phase_r == PH_HIGH) begin
            shift_nxt = {shift_r[VALUE_WIDTH-2:0], in_data.data_level};
            bits_nxt  = bits_r + 6'd1;
            phase_nxt = PH_LOW;
          end else begin
            pulses_nxt = pulses_r + 8'd1;
            phase_nxt  = PH_XLOW;
          end
        end else begin
          tick_nxt = tick_inc[15:0];
        end
      end
      PH_LOW, PH_XLOW: begin
        clk_nxt = 1'b0;
        if (tick_inc >= half_eff) begin
          adv_go = 1'b1;
        end else begin
          tick_nxt = tick_inc[15:0];
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (in_data.start_req) begin
          clk_nxt    = cfg.initial_clock_level;
          bits_nxt   = 6'd0;
          pulses_nxt = 8'd0;
          tick_nxt   = 16'd0;
          wait_nxt   = 16'd0;
          shift_nxt  = '0;
          phase_nxt  = PH_WAIT;
        end
      end
    endcase

    // Pick what follows ready detection or the end of a low phase
    if (adv_go) begin
      tick_nxt = 16'd0;
      if (bits_r < cfg.bit_count) begin
        phase_nxt = PH_HIGH;
      end else if (pulses_r < cfg.extra_pulses) begin
        phase_nxt = PH_XHIGH;
      end else begin
        phase_nxt = PH_IDLE;
        res_done  = 1'b1;
        res_val   = shift_r;
      end
    end
  end

  // Fit the kept value to the output field
  assign res_ext         = {{OW{1'b0}}, res_val};
  assign res.clock_level = clk_nxt;
  assign res.busy_res    = (phase_nxt != PH_IDLE);
  assign res.done_res    = res_done;
  assign res.timed_out   = res_tmo;
  assign res.value       = res_ext[OW-1:0];

  // Hold sequencer state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      clk_r       <= 1'b0;
      bits_r      <= 6'd0;
      pulses_r    <= 8'd0;
      tick_r      <= 16'd0;
      wait_r      <= 16'd0;
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        clk_r       <= clk_nxt;
        bits_r      <= bits_nxt;
        pulses_r    <= pulses_nxt;
        tick_r      <= tick_nxt;
        wait_r      <= wait_nxt;
        shift_r     <= shift_nxt;
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Timeout only comes with done
  a_tmo_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.timed_out |-> out_data_r.done_res)
    else $error("timeout reported without done");

  // A finished read is no longer busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done reported while busy");

  // A held result is never dropped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled result lost");

  // Busy result matches the sequencer state it left behind
  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_data_r.busy_res == (phase_r != PH_IDLE))
    else $error("busy flag disagrees with sequencer state");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_shift_in_reader_core.
// Drives one tick per input beat, mostly as well-formed reads (start, a run of
// not-ready polls, then random data bits), mixed with noise ticks. A tick-level
// model predicts the result beat for every accepted tick. Each result beat is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

class shift_in_scoreboard;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW, PH_XHIGH, PH_XLOW
  } seq_phase_t;

  // Register copies
  logic [5:0]  bit_count;
  logic [7:0]  extra_pulses;
  logic [15:0] half_ticks;
  logic        init_clk;
  logic        ready_lvl;
  logic [15:0] wait_limit;

  // Sequencer state
  seq_phase_t  phase;
  logic        clk_lvl;
  logic [5:0]  bits_done;
  logic [7:0]  pulses_done;
  int          tick_cnt;
  int          wait_cnt;
  logic [31:0] shift_reg;

  ssir_pkg::out_t tick_result;
  ssir_pkg::out_t tick_results[$];

  int errors;
  int ticks;
  int beats_checked;
  int reads_ok;
  int long_reads;
  int timeouts;

  function new();
    bit_count    = ssir_pkg::RST_BIT_COUNT;
    extra_pulses = ssir_pkg::RST_EXTRA_PULSE;
    half_ticks   = ssir_pkg::RST_HALF_PERIOD;
    init_clk     = ssir_pkg::RST_INIT_CLOCK;
    ready_lvl    = ssir_pkg::RST_READY_LEVEL;
    wait_limit   = ssir_pkg::RST_WAIT_LIMIT;
    phase        = PH_IDLE;
    clk_lvl      = 1'b0;
    bits_done    = '0;
    pulses_done  = '0;
    tick_cnt     = 0;
    wait_cnt     = 0;
    shift_reg    = '0;
  endfunction

  function void set_reg(logic [ssir_pkg::CFG_IDX_W-1:0] idx,
                        logic [ssir_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      ssir_pkg::CFG_IDX_BIT_COUNT:   bit_count    = val[5:0];
      ssir_pkg::CFG_IDX_EXTRA_PULSE: extra_pulses = val[7:0];
      ssir_pkg::CFG_IDX_HALF_PERIOD: half_ticks   = val;
      ssir_pkg::CFG_IDX_INIT_CLOCK:  init_clk     = val[0];
      ssir_pkg::CFG_IDX_READY_LEVEL: ready_lvl    = val[0];
      ssir_pkg::CFG_IDX_WAIT_LIMIT:  wait_limit   = val;
      default: ;
    endcase
  endfunction

  function bit is_idle();
    return phase == PH_IDLE;
  endfunction

  function int pending();
    return tick_results.size();
  endfunction

  // Pick the next pulse after a low phase or the ready poll, or finish the read
  function void next_pulse();
    tick_cnt = 0;
    if (bits_done < bit_count) begin
      phase = PH_HIGH;
    end else if (pulses_done < extra_pulses) begin
      phase = PH_XHIGH;
    end else begin
      phase = PH_IDLE;
      tick_result.done_res = 1'b1;
      tick_result.value = shift_reg;
      reads_ok++;
      if (bit_count > 32) long_reads++;
    end
  endfunction

  // Step the sequencer by one accepted tick and queue its result beat
  function void note_tick(ssir_pkg::in_t t);
    int half_eff;
    int limit_eff;
    half_eff = (half_ticks == 0) ? 1 : int'(half_ticks);
    limit_eff = (wait_limit == 0) ? 1 : int'(wait_limit);
    tick_result = '0;
    ticks++;
    case (phase)
      PH_WAIT: begin
        if (t.data_level == ready_lvl) begin
          next_pulse();
        end else if (wait_cnt + 1 >= limit_eff) begin
          wait_cnt = 0;
          phase = PH_IDLE;
          tick_result.done_res = 1'b1;
          tick_result.timed_out = 1'b1;
          tick_result.value = '1;
          timeouts++;
        end else begin
          wait_cnt++;
        end
      end
      PH_HIGH, PH_XHIGH: begin
        clk_lvl = 1'b1;
        tick_cnt++;
        if (tick_cnt >= half_eff) begin
          tick_cnt = 0;
          if (phase == PH_HIGH) begin
            shift_reg = {shift_reg[30:0], t.data_level};
            bits_done++;
            phase = PH_LOW;
          end else begin
            pulses_done++;
            phase = PH_XLOW;
          end
        end
      end
      PH_LOW, PH_XLOW: begin
        clk_lvl = 1'b0;
        tick_cnt++;
        if (tick_cnt >= half_eff) next_pulse();
      end
      default: begin
        phase = PH_IDLE;
        if (t.start_req) begin
          clk_lvl = init_clk;
          bits_done = '0;
          pulses_done = '0;
          tick_cnt = 0;
          wait_cnt = 0;
          shift_reg = '0;
          phase = PH_WAIT;
        end
      end
    endcase
    tick_result.clock_level = clk_lvl;
    tick_result.busy_res = (phase != PH_IDLE);
    tick_results.push_back(tick_result);
  endfunction

  task report(string msg);
    if (errors < 50) $display("tb: mismatch at result %0d: %s", beats_checked, msg);
    errors++;
  endtask

  task check_result(ssir_pkg::out_t got);
    ssir_pkg::out_t want;
    beats_checked++;
    if (tick_results.size() == 0) begin
      report("result beat with nothing expected");
      return;
    end
    want = tick_results.pop_front();
    if (got.clock_level !== want.clock_level)
      report($sformatf("clock_level got %b want %b", got.clock_level, want.clock_level));
    if (got.busy_res !== want.busy_res)
      report($sformatf("busy_res got %b want %b", got.busy_res, want.busy_res));
    if (got.done_res !== want.done_res)
      report($sformatf("done_res got %b want %b", got.done_res, want.done_res));
    if (got.timed_out !== want.timed_out)
      report($sformatf("timed_out got %b want %b", got.timed_out, want.timed_out));
    if (got.value !== want.value)
      report($sformatf("value got %h want %h", got.value, want.value));
  endtask

endclass

module tb;

  localparam int HOLD_CYCLES = 200;

  logic clk;
  logic rst_n = 1'b0;

  logic           in_valid = 1'b0;
  logic           in_stall;
  ssir_pkg::in_t  in_data = '0;

  logic           out_valid;
  logic           out_stall = 1'b0;
  ssir_pkg::out_t out_data;

  logic                            cfg_we = 1'b0;
  logic [ssir_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ssir_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bit tx_gaps_on = 1'b1;
  bit rx_stall_on = 1'b1;
  bit hold_req = 1'b0;
  int settings_used = 0;

  shift_in_scoreboard sb = new();

  serial_shift_in_reader_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= rx_stall_on && ($urandom_range(0, 99) < 20);
    end
  end

  // Check every result beat that leaves the block
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Offer one tick and hold it until the block takes it
  task automatic send_tick(input logic start, input logic data);
    ssir_pkg::in_t t;
    t.start_req = start;
    t.data_level = data;
    if (tx_gaps_on && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(t);
  endtask

  // Run ticks with random data until the current read is over
  task automatic finish_read();
    while (!sb.is_idle())
      send_tick($urandom_range(0, 99) < 10, $urandom_range(0, 1) != 0);
  endtask

  // One read: start, a run of not-ready polls, then random data
  task automatic do_read(input int misses);
    int n;
    finish_read();
    send_tick(1'b1, $urandom_range(0, 1) != 0);
    n = 0;
    while (n < misses && !sb.is_idle()) begin
      send_tick($urandom_range(0, 99) < 10, ~sb.ready_lvl);
      n++;
    end
    finish_read();
  endtask

  task automatic noise_ticks(input int n);
    repeat (n) send_tick($urandom_range(0, 99) < 30, $urandom_range(0, 1) != 0);
  endtask

  // Drain: end the read, drop valid and wait out every pending result
  task automatic settle();
    finish_read();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ssir_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ssir_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(input int bits, input int extra, input int half,
                               input int init, input int ready, input int limit);
    write_reg(ssir_pkg::CFG_IDX_BIT_COUNT, ssir_pkg::CFG_DATA_W'(bits));
    write_reg(ssir_pkg::CFG_IDX_EXTRA_PULSE, ssir_pkg::CFG_DATA_W'(extra));
    write_reg(ssir_pkg::CFG_IDX_HALF_PERIOD, ssir_pkg::CFG_DATA_W'(half));
    write_reg(ssir_pkg::CFG_IDX_INIT_CLOCK, ssir_pkg::CFG_DATA_W'(init));
    write_reg(ssir_pkg::CFG_IDX_READY_LEVEL, ssir_pkg::CFG_DATA_W'(ready));
    write_reg(ssir_pkg::CFG_IDX_WAIT_LIMIT, ssir_pkg::CFG_DATA_W'(limit));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_setting();
    int bits;
    int extra;
    int half;
    int limit;
    bits = ($urandom_range(0, 99) < 10) ? $urandom_range(33, 63) : $urandom_range(0, 32);
    extra = ($urandom_range(0, 99) < 10) ? $urandom_range(9, 40) : $urandom_range(0, 4);
    half = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 3);
    limit = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 12);
    apply_setting(bits, extra, half, $urandom_range(0, 1), $urandom_range(0, 1), limit);
  endtask

  initial begin
    int rand_base;
    int phase_end;
    int phase_no;
    int limit_eff;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: 24 bits, one gain pulse, ready low
    do_read(0);
    do_read(3);
    noise_ticks(4);
    settle();

    // No bits, no pulses: done on the ready tick; one failed poll times out
    apply_setting(0, 0, 1, 0, 0, 1);
    do_read(0);
    do_read(1);
    settle();

    // Zero half period and zero wait limit act as one; clock starts each read high
    apply_setting(8, 2, 0, 1, 1, 0);
    do_read(1);
    do_read(0);
    noise_ticks(3);
    settle();

    // Long read drops the oldest bits; maximum extra pulses
    apply_setting(63, 255, 1, 0, 1, 5);
    do_read(2);
    settle();

    apply_setting(32, 0, 2, 1, 0, 65535);
    do_read(4);
    settle();

    // Widest half period, widest and short wait limits, run without idling
    tx_gaps_on = 1'b0;
    rx_stall_on = 1'b0;
    apply_setting(0, 0, 65535, 0, 0, 65535);
    do_read(0);
    do_read(5);
    settle();
    apply_setting(1, 0, 65535, 1, 1, 3);
    do_read(3);
    settle();
    tx_gaps_on = 1'b1;
    rx_stall_on = 1'b1;

    // Random settings, mostly well-formed reads with some noise
    rand_base = sb.ticks;
    phase_no = 0;
    while (sb.ticks - rand_base < 1000 || phase_no < 3) begin
      random_setting();
      if (phase_no == 1) hold_req = 1'b1;
      tx_gaps_on = (phase_no != 2);
      rx_stall_on = (phase_no != 2);
      limit_eff = (sb.wait_limit == 0) ? 1 : int'(sb.wait_limit);
      phase_end = sb.ticks + $urandom_range(150, 300);
      while (sb.ticks < phase_end) begin
        if ($urandom_range(0, 99) < 85) begin
          if ($urandom_range(0, 99) < 20) do_read(limit_eff);
          else do_read($urandom_range(0, limit_eff - 1));
        end else begin
          noise_ticks($urandom_range(1, 8));
        end
      end
      settle();
      phase_no++;
    end
    tx_gaps_on = 1'b1;
    rx_stall_on = 1'b1;

    $display("tb: %0d ticks over %0d register settings", sb.ticks, settings_used);
    $display("tb: %0d reads completed (%0d longer than 32 bits), %0d timeouts",
             sb.reads_ok, sb.long_reads, sb.timeouts);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/ssir_pkg.sv
rtl/ssir_cfg.sv
rtl/serial_shift_in_reader_core.sv
sim/tb.sv
